[hdl/assert_macros.svh]
// Assertion macros used by the translator core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset masked.
`define EMOT_ASSERT_IMP(lbl, ck, rn, pre, con, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (con)) \
		else $error(msg);

// Next-cycle implication, reset masked.
`define EMOT_ASSERT_NXT(lbl, ck, rn, pre, con, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (con)) \
		else $error(msg);

`endif

[hdl/emot_pkg.sv]
// Types and codes of the extent map offset translator.
`default_nettype none
package emot_pkg;

	localparam int DW = 64;

	localparam logic [1:0] REQ_APPEND = 2'd0;
	localparam logic [1:0] REQ_CLEAR  = 2'd1;
	localparam logic [1:0] REQ_QUERY  = 2'd2;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_INVAL    = 3'd1;
	localparam logic [2:0] ST_OVERFLOW = 3'd2;
	localparam logic [2:0] ST_RANGE    = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	// Query token walking the cell row.
	typedef struct packed {
		logic          hit;   // holding extent found
		logic          ovf;   // query end wrapped past 2^64-1
		logic [DW-1:0] off;   // query offset
		logic [DW-1:0] len;   // query length
		logic [DW-1:0] rel;   // offset relative to the current extent start
		logic [DW-1:0] base;  // base of holding extent
		logic [DW-1:0] elen;  // length of holding extent
	} scan_tok_t;

	typedef struct packed {
		logic [2:0]    status;
		logic [DW-1:0] device_address;
		logic [DW-1:0] error_offset;
	} scan_rslt_t;

endpackage
`default_nettype wire

[hdl/emot_req_if.sv]
// Request channel: valid/ready plus request payload.
`default_nettype none
interface emot_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [63:0] extent_device_base;
	logic [63:0] extent_byte_length;
	logic [63:0] query_offset;
	logic [63:0] query_length;

	modport source (
		output valid, req_type, extent_device_base, extent_byte_length,
		output query_offset, query_length,
		input  ready
	);
	modport sink (
		input  valid, req_type, extent_device_base, extent_byte_length,
		input  query_offset, query_length,
		output ready
	);
endinterface
`default_nettype wire

[hdl/emot_rsp_if.sv]
// Response channel: valid/ready plus result payload.
`default_nettype none
interface emot_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [63:0] device_address;
	logic [63:0] error_offset;

	modport source (output valid, status, device_address, error_offset, input ready);
	modport sink (input valid, status, device_address, error_offset, output ready);
endinterface
`default_nettype wire

[hdl/extent_map_offset_translator_core.sv]
// Extent map offset translator: top level with the extent cell row.
//
//   port | dir | holds
//   -----+-----+---------------------------------------------------------------
//   req  | in  | req_type, extent_device_base/_byte_length, query_offset/_length
//   rsp  | out | status, device_address, error_offset (one item per request)
//
// Append, clear and unused requests: the result goes to the pending slot on
// acceptance, then to the output register. Query: the token walks every cell
// of the row (one cell per cycle), then the check stage and both result registers.
// One request is in work at a time; the next is taken once its result has left
// the pending slot, even while the output register still waits on rsp.ready.
// arst_n clears the extent count and all valid flags; extent data is not reset.
`default_nettype none
`include "assert_macros.svh"
module extent_map_offset_translator_core #(
	parameter int MAX_EXTENTS = 64
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	emot_req_if.sink    req,
	emot_rsp_if.source  rsp
);
	import emot_pkg::*;

	localparam int CNT_W = $clog2(MAX_EXTENTS + 1);

	logic [CNT_W-1:0] count_q;     // extents stored
	logic             scan_q;      // query in the cell row or check stage
	logic             pend_vld_q;  // finished result not yet in output register
	scan_rslt_t       pend_q;
	logic             out_vld_q;
	scan_rslt_t       out_q;

	logic             in_ready;
	logic             in_go;
	logic             is_query;
	logic             tbl_full;
	logic             pend_move;
	logic [DW:0]      end_sum;
	scan_rslt_t       imm_rslt;

	logic [MAX_EXTENTS-1:0] wr_sel;
	logic [MAX_EXTENTS-1:0] live;
	logic [MAX_EXTENTS:0]   chain_vld;
	scan_tok_t              chain_tok [MAX_EXTENTS+1];

	logic       fin_vld;
	scan_rslt_t fin_rslt;

	// ---- input side ----
	assign in_ready  = !scan_q && !pend_vld_q;
	assign req.ready = in_ready;
	assign in_go     = req.valid && in_ready;
	assign is_query  = req.req_type == REQ_QUERY;
	assign tbl_full  = count_q == CNT_W'(MAX_EXTENTS);

	// query end overflow is caught here and rides the token to the check stage
	assign end_sum = {1'b0, req.query_offset} + {1'b0, req.query_length};

	always_comb begin
		imm_rslt = '{status: ST_OK, device_address: '0, error_offset: '0};
		if (req.req_type == REQ_APPEND && tbl_full) begin
			imm_rslt.status = ST_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_go) begin
			case (req.req_type)
				REQ_APPEND: begin
					if (!tbl_full) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				REQ_CLEAR: begin
					count_q <= '0;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	// ---- cell row ----
	assign chain_vld[0] = in_go && is_query;
	assign chain_tok[0] = '{
		hit:  1'b0,
		ovf:  end_sum[DW],
		off:  req.query_offset,
		len:  req.query_length,
		rel:  req.query_offset,
		base: '0,
		elen: '0
	};

	for (genvar i = 0; i < MAX_EXTENTS; i++) begin : g_cell
		// count is frozen while a query walks, so live is a plain compare
		assign wr_sel[i] = in_go && (req.req_type == REQ_APPEND) && !tbl_full
			&& (count_q == CNT_W'(i));
		assign live[i]   = count_q > CNT_W'(i);

		emot_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.wr_en       (wr_sel[i]),
			.wr_base     (req.extent_device_base),
			.wr_len      (req.extent_byte_length),
			.live        (live[i]),
			.tok_vld_in  (chain_vld[i]),
			.tok_in      (chain_tok[i]),
			.tok_vld_out (chain_vld[i+1]),
			.tok_out     (chain_tok[i+1])
		);
	end

	emot_finish u_finish (
		.clk      (clk),
		.arst_n   (arst_n),
		.tok_vld  (chain_vld[MAX_EXTENTS]),
		.tok      (chain_tok[MAX_EXTENTS]),
		.rslt_vld (fin_vld),
		.rslt     (fin_rslt)
	);

	// ---- result side: pending slot, then output register ----
	assign pend_move = pend_vld_q && (!out_vld_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q     <= 1'b0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (in_go && is_query) begin
				scan_q <= 1'b1;
			end else if (fin_vld) begin
				scan_q <= 1'b0;
			end

			if ((in_go && !is_query) || fin_vld) begin
				pend_vld_q <= 1'b1;
			end else if (pend_move) begin
				pend_vld_q <= 1'b0;
			end

			if (pend_move) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_go && !is_query) begin
			pend_q <= imm_rslt;
		end else if (fin_vld) begin
			pend_q <= fin_rslt;
		end
		if (pend_move) begin
			out_q <= pend_q;
		end
	end

	assign rsp.valid          = out_vld_q;
	assign rsp.status         = out_q.status;
	assign rsp.device_address = out_q.device_address;
	assign rsp.error_offset   = out_q.error_offset;

	// ---- checks ----
	`EMOT_ASSERT_NXT(a_one_in_work, clk, arst_n, in_go, !in_ready, "item taken while busy")
	`EMOT_ASSERT_IMP(a_one_token, clk, arst_n, 1'b1, $onehot0(chain_vld), "two tokens in row")
	`EMOT_ASSERT_IMP(a_fin_in_scan, clk, arst_n, fin_vld, scan_q && !pend_vld_q, "stray query result")
	`EMOT_ASSERT_IMP(a_count_max, clk, arst_n, 1'b1, count_q <= CNT_W'(MAX_EXTENTS), "count past depth")

endmodule
`default_nettype wire

[hdl/emot_cell.sv]
// One extent cell: stores an extent and steps the query token past it.
`default_nettype none
module emot_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [63:0]       wr_base,
	input  wire logic [63:0]       wr_len,
	input  wire logic              live,
	input  wire logic              tok_vld_in,
	input  wire emot_pkg::scan_tok_t tok_in,
	output logic                   tok_vld_out,
	output emot_pkg::scan_tok_t    tok_out
);
	import emot_pkg::*;

	logic [DW-1:0] base_q;
	logic [DW-1:0] len_q;
	logic          act;
	logic [DW:0]   diff;
	scan_tok_t     tok_nxt;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			base_q <= wr_base;
			len_q  <= wr_len;
		end
	end

	// rel < len shows as the borrow of rel - len; zero-length extents never hit
	assign act  = tok_vld_in && !tok_in.hit && !tok_in.ovf && live;
	assign diff = {1'b0, tok_in.rel} - {1'b0, len_q};

	always_comb begin
		tok_nxt = tok_in;
		if (act) begin
			if (diff[DW]) begin
				tok_nxt.hit  = 1'b1;
				tok_nxt.base = base_q;
				tok_nxt.elen = len_q;
			end else begin
				tok_nxt.rel = diff[DW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_vld_out <= 1'b0;
		end else begin
			tok_vld_out <= tok_vld_in;
		end
	end

	always_ff @(posedge clk) begin
		tok_out <= tok_nxt;
	end

endmodule
`default_nettype wire

[hdl/emot_finish.sv]
// Final checks on the token leaving the cell row; one register stage.
`default_nettype none
module emot_finish (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              tok_vld,
	input  wire emot_pkg::scan_tok_t tok,
	output logic                   rslt_vld,
	output emot_pkg::scan_rslt_t   rslt
);
	import emot_pkg::*;

	logic          vld_s1;
	logic          hit_s1;
	logic          ovf_s1;
	logic [DW-1:0] off_s1;
	logic [DW-1:0] len_s1;
	logic [DW-1:0] rel_s1;
	logic [DW-1:0] base_s1;
	logic [DW-1:0] room_s1;
	logic [DW:0]   sum_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= tok_vld;
		end
	end

	always_ff @(posedge clk) begin
		hit_s1  <= tok.hit;
		ovf_s1  <= tok.ovf;
		off_s1  <= tok.off;
		len_s1  <= tok.len;
		rel_s1  <= tok.rel;
		base_s1 <= tok.base;
		room_s1 <= tok.elen - tok.rel;
		sum_s1  <= {1'b0, tok.base} + {1'b0, tok.rel};
	end

	assign rslt_vld = vld_s1;

	always_comb begin
		rslt = '{status: ST_OK, device_address: '0, error_offset: '0};
		if (ovf_s1) begin
			rslt.status       = ST_OVERFLOW;
			rslt.error_offset = off_s1;
		end else if (!hit_s1) begin
			rslt.status       = ST_RANGE;
			rslt.error_offset = off_s1;
		end else if (len_s1 > room_s1) begin
			rslt.status       = ST_INVAL;
			rslt.error_offset = rel_s1;
		end else if (sum_s1[DW]) begin
			rslt.status       = ST_OVERFLOW;
			rslt.error_offset = base_s1;
		end else begin
			rslt.device_address = sum_s1[DW-1:0];
		end
	end

endmodule
`default_nettype wire
